// ----- rtl/text_encoding_detector_core_assert.svh -----
// ----------------------------------------------------------------------------
// text_encoding_detector_core_assert.svh
// Assertion macros shared by the encoding detector RTL. They expect clk and
// rst_n in the scope of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef TEXT_ENCODING_DETECTOR_CORE_ASSERT_SVH
`define TEXT_ENCODING_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TED_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ted_pkg.sv -----
// ----------------------------------------------------------------------------
// ted_pkg
// Types and constants of the text encoding detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ted_pkg;

    localparam int COUNT_WIDTH = 32;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [2:0] {
        ENC_ANSI    = 3'd0,
        ENC_BINARY  = 3'd1,
        ENC_UTF16LE = 3'd2,
        ENC_UTF16BE = 3'd3,
        ENC_UTF8    = 3'd4
    } encoding_t;

    localparam logic [7:0] LIMIT_RESET   = 8'd2;
    localparam logic [7:0] BYTE_FF       = 8'hFF;
    localparam logic [7:0] BYTE_FE       = 8'hFE;
    localparam logic [7:0] UTF8_BOM0     = 8'hEF;
    localparam logic [7:0] UTF8_BOM1     = 8'hBB;
    localparam logic [7:0] UTF8_BOM2     = 8'hBF;
    localparam logic [2:0] ZERO_BYTE_MIN = 3'd3;
    localparam logic [2:0] ZERO_BYTE_MAX = 3'd7;
    localparam logic [7:0] ZERO_WORD_MAX = 8'd255;

    // Buffer statistics after the current byte, fed to the classifier.
    typedef struct packed {
        count_t     len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] zero_words;
        logic [2:0] zero_bytes;
        logic       illegal;
        logic       cont_err;
        logic       multibyte;
    } summary_t;

endpackage

// ----- rtl/ted_if.sv -----
// ----------------------------------------------------------------------------
// ted_if
// Valid/ready stream interfaces: input bytes and encoding results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ted_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ted_enc_if;
    logic       valid;
    logic       ready;
    logic [2:0] encoding;

    modport source (output valid, output encoding, input ready);
    modport sink   (input valid, input encoding, output ready);
endinterface

// ----- rtl/ted_accum.sv -----
// ----------------------------------------------------------------------------
// ted_accum
// Per-buffer statistics: counts, leading bytes, zero words, UTF-8 walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ted_accum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output ted_pkg::summary_t summary
);
    import ted_pkg::*;

    localparam count_t CountMax = '1;

    count_t     count_reg,      count_next;
    logic [7:0] lead_reg [3],   lead_next [3];
    logic       pend_reg,       pend_next;
    logic [7:0] zword_reg,      zword_next;
    logic [2:0] zbyte_reg,      zbyte_next;
    logic       illegal_reg,    illegal_next;
    logic [7:0] win_reg [4],    win_next [4];
    logic [1:0] skip_reg,       skip_next;
    logic       mb_reg,         mb_next;
    logic       cerr_reg,       cerr_next;

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    always_comb
    begin
        count_t n;
        n = count_reg;

        for (int i = 0; i < 3; i++)
        begin
            lead_next[i] = lead_reg[i];
        end
        if (n < count_t'(3))
        begin
            lead_next[n[1:0]] = data_byte;
        end

        zbyte_next = zbyte_reg;
        if (n >= count_t'(2) && data_byte == 8'h00 && zbyte_reg < ZERO_BYTE_MAX)
        begin
            zbyte_next = zbyte_reg + 3'd1;
        end

        zword_next = zword_reg;
        if (!n[0])
        begin
            if (n >= count_t'(2) && pend_reg && zword_reg < ZERO_WORD_MAX)
            begin
                zword_next = zword_reg + 8'd1;
            end
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = (win_reg[3] == 8'h00) && (data_byte == 8'h00);
        end

        illegal_next = illegal_reg || data_byte == 8'hC0 || data_byte == 8'hC1
                       || data_byte >= 8'hF5;

        // UTF-8 walk over the lead byte four positions back
        skip_next = skip_reg;
        mb_next   = mb_reg;
        cerr_next = cerr_reg;
        if (n >= count_t'(4))
        begin
            if (skip_reg != 2'd0)
            begin
                skip_next = skip_reg - 2'd1;
            end
            else if (win_reg[0][7:5] == 3'b110)
            begin
                if (!is_cont(win_reg[1])) cerr_next = 1'b1;
                else                      mb_next   = 1'b1;
                skip_next = 2'd1;
            end
            else if (win_reg[0][7:4] == 4'b1110)
            begin
                if (!is_cont(win_reg[1]) || !is_cont(win_reg[2])) cerr_next = 1'b1;
                else                                              mb_next   = 1'b1;
                skip_next = 2'd2;
            end
            else if (win_reg[0][7:3] == 5'b11110)
            begin
                if (!is_cont(win_reg[1]) || !is_cont(win_reg[2]) || !is_cont(win_reg[3]))
                    cerr_next = 1'b1;
                else
                    mb_next   = 1'b1;
                skip_next = 2'd3;
            end
        end

        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = win_reg[3];
        win_next[3] = data_byte;

        count_next = (count_reg == CountMax) ? count_reg : count_reg + count_t'(1);
    end

    assign summary.len        = count_next;
    assign summary.b0         = lead_next[0];
    assign summary.b1         = lead_next[1];
    assign summary.b2         = lead_next[2];
    assign summary.zero_words = zword_next;
    assign summary.zero_bytes = zbyte_next;
    assign summary.illegal    = illegal_next;
    assign summary.cont_err   = cerr_next;
    assign summary.multibyte  = mb_next;

    // Last byte closes the buffer: everything returns to the empty state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            zword_reg   <= '0;
            zbyte_reg   <= '0;
            illegal_reg <= 1'b0;
            skip_reg    <= '0;
            mb_reg      <= 1'b0;
            cerr_reg    <= 1'b0;
            for (int i = 0; i < 3; i++) lead_reg[i] <= '0;
            for (int i = 0; i < 4; i++) win_reg[i]  <= '0;
        end
        else if (advance)
        begin
            if (last_byte)
            begin
                count_reg   <= '0;
                pend_reg    <= 1'b0;
                zword_reg   <= '0;
                zbyte_reg   <= '0;
                illegal_reg <= 1'b0;
                skip_reg    <= '0;
                mb_reg      <= 1'b0;
                cerr_reg    <= 1'b0;
                for (int i = 0; i < 3; i++) lead_reg[i] <= '0;
                for (int i = 0; i < 4; i++) win_reg[i]  <= '0;
            end
            else
            begin
                count_reg   <= count_next;
                pend_reg    <= pend_next;
                zword_reg   <= zword_next;
                zbyte_reg   <= zbyte_next;
                illegal_reg <= illegal_next;
                skip_reg    <= skip_next;
                mb_reg      <= mb_next;
                cerr_reg    <= cerr_next;
                for (int i = 0; i < 3; i++) lead_reg[i] <= lead_next[i];
                for (int i = 0; i < 4; i++) win_reg[i]  <= win_next[i];
            end
        end
    end

endmodule

// ----- rtl/ted_classify.sv -----
// ----------------------------------------------------------------------------
// ted_classify
// Priority decision from buffer statistics to an encoding code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ted_classify (
    input  ted_pkg::summary_t  summary,
    input  logic [7:0]         limit,
    output ted_pkg::encoding_t encoding
);
    import ted_pkg::*;

    always_comb
    begin
        if (summary.len < count_t'(2))
            encoding = ENC_ANSI;
        else if (summary.zero_words > limit)
            encoding = ENC_BINARY;
        else if (summary.b0 == BYTE_FF && summary.b1 == BYTE_FE)
            encoding = ENC_UTF16LE;
        else if (summary.b0 == BYTE_FE && summary.b1 == BYTE_FF)
            encoding = ENC_UTF16BE;
        else if (summary.zero_bytes > ZERO_BYTE_MIN && !summary.len[0])
            encoding = ENC_UTF16LE;
        else if (summary.len < count_t'(3))
            encoding = ENC_ANSI;
        else if (summary.b0 == UTF8_BOM0 && summary.b1 == UTF8_BOM1
                 && summary.b2 == UTF8_BOM2)
            encoding = ENC_UTF8;
        else if (summary.illegal || summary.cont_err)
            encoding = ENC_ANSI;
        else if (summary.multibyte)
            encoding = ENC_UTF8;
        else
            encoding = ENC_ANSI;
    end

endmodule

// ----- rtl/text_encoding_detector_core.sv -----
// ----------------------------------------------------------------------------
// text_encoding_detector_core
// Classifies a byte buffer as ansi, binary, UTF-16 LE/BE or UTF-8.
//
//   channel   dir  handshake      payload
//   byte_in   in   valid/ready    data_byte[7:0], last_byte
//   enc_out   out  valid/ready    encoding[2:0]
//   cfg       in   cfg_we         cfg_wdata[7:0] (zero-word limit)
//
// One byte transaction per cycle while no last byte is held back; the input
// register plus the statistics update and classifier set that figure.
// The last byte passes the input register, then the result register, to enc_out.
// Non-last bytes never wait on enc_out; a last byte waits in the input
// register only while a previous result sits untaken in the result register.
// Reset: all buffer state empty, zero-word limit 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_encoding_detector_core_assert.svh"

module text_encoding_detector_core (
    input  logic        clk,
    input  logic        rst_n,
    ted_byte_if.sink    byte_in,
    ted_enc_if.source   enc_out,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);
    import ted_pkg::*;

    // Input register stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Result register stage
    logic       out_valid_reg, out_valid_next;
    encoding_t  out_enc_reg;

    logic [7:0] limit_reg;

    logic       out_free;
    logic       s1_advance;
    summary_t   summary;
    encoding_t  enc_calc;

    // A byte leaves the input register unless it needs the result register
    // and that register is still occupied.
    assign out_free      = !out_valid_reg || enc_out.ready;
    assign s1_advance    = s1_valid_reg && (!s1_last_reg || out_free);
    assign byte_in.ready = !s1_valid_reg || s1_advance;

    assign s1_valid_next  = byte_in.valid ? 1'b1 : (s1_valid_reg && !s1_advance);
    assign out_valid_next = (s1_advance && s1_last_reg) ? 1'b1
                          : (enc_out.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            if (byte_in.ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
        if (s1_advance && s1_last_reg)
        begin
            out_enc_reg <= enc_calc;
        end
    end

    // Statistics are updated as each byte leaves the input register; the
    // classifier sees the values including that byte.
    ted_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_advance),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .summary   (summary)
    );

    ted_classify u_classify (
        .summary  (summary),
        .limit    (limit_reg),
        .encoding (enc_calc)
    );

    assign enc_out.valid    = out_valid_reg;
    assign enc_out.encoding = out_enc_reg;

    `TED_ASSERT(a_last_blocks_input, s1_valid_reg && s1_last_reg && out_valid_reg && !enc_out.ready, !byte_in.ready, "last byte passed a full result register")
    `TED_ASSERT_NEXT(a_result_follows_last, s1_advance && s1_last_reg, enc_out.valid, "no result after last byte")
    `TED_ASSERT(a_code_range, enc_out.valid, enc_out.encoding <= 3'(ENC_UTF8), "encoding code out of range")
    `TED_ASSERT(a_no_advance_empty, !s1_valid_reg, !s1_advance, "advance without a byte")

endmodule

// ----- dv/text_encoding_detector_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_encoding_detector_core_tb
// Self-checking bench for the encoding detector. Byte buffers go in on the
// byte stream, and a bit-accurate tracker in the bench keeps the per-buffer
// statistics and predicts each encoding. The checker compares every result
// transaction with the oldest prediction. Directed buffers cover the
// byte-order marks, the UTF-8 walk, null counting, limit extremes and counter
// saturation. Random buffers of mixed text kinds follow, with random idling
// on both sides, a long result stall and limit rewrites between phases.
// ----------------------------------------------------------------------------

module text_encoding_detector_core_tb;

    import ted_pkg::*;

    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no transaction
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_BYTES    = 420;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 4;     // settle margin after the last result
    localparam int CFG_INTERVAL    = 200;   // random bytes between limit writes
    localparam int RESET_CYCLES    = 6;

    typedef logic [7:0] octet_t;

    typedef enum int {
        TXT_ASCII,
        TXT_UTF8,
        TXT_UTF16LE,
        TXT_UTF16BE,
        TXT_NULLS,
        TXT_NOISE
    } text_kind_t;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    ted_byte_if byte_in ();
    ted_enc_if  enc_out ();

    text_encoding_detector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .enc_out   (enc_out),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Buffer statistics tracker: mirrors the block's per-buffer state.
    // ------------------------------------------------------------------
    logic [7:0]  zero_word_limit;
    count_t      buf_len;
    logic [23:0] head;           // bytes 0..2, byte 0 in the low bits
    logic        pair_was_zero;  // last even-aligned pair was 00 00
    logic [7:0]  zero_words;
    logic [2:0]  zero_bytes;
    logic        saw_illegal;
    octet_t      lookback [4];   // [3] is the newest byte
    logic [1:0]  cont_to_skip;
    logic        saw_multibyte;
    logic        saw_cont_err;

    encoding_t   expected_enc_q [$];

    octet_t      pkt [$];        // buffer being built for sending

    int          mismatches;
    int          bytes_sent;
    int          idle_cycles;
    int          hold_off_len;
    bit          src_idle_on;
    bit          sink_idle_on;

    function automatic logic is_cont(input octet_t b);
        return b[7:6] == 2'b10;
    endfunction

    task automatic clear_buffer_stats();
        buf_len       = '0;
        head          = '0;
        pair_was_zero = 1'b0;
        zero_words    = '0;
        zero_bytes    = '0;
        saw_illegal   = 1'b0;
        lookback      = '{default: 8'h00};
        cont_to_skip  = '0;
        saw_multibyte = 1'b0;
        saw_cont_err  = 1'b0;
    endtask

    // Fold one accepted byte into the statistics; on the last byte, queue
    // the encoding the block must produce and start a fresh buffer.
    task automatic absorb_byte(input octet_t b, input logic last);
        count_t    n;
        encoding_t verdict;
        n = buf_len;

        case (n)
            0: head[7:0]   = b;
            1: head[15:8]  = b;
            2: head[23:16] = b;
            default: ;
        endcase

        if (n >= 2 && b == 8'h00 && zero_bytes != ZERO_BYTE_MAX)
            zero_bytes++;

        // A zero pair only counts once a byte follows it at the next even index.
        if (!n[0])
        begin
            if (n >= 2 && pair_was_zero && zero_words != ZERO_WORD_MAX)
                zero_words++;
            pair_was_zero = 1'b0;
        end
        else
            pair_was_zero = (lookback[3] == 8'h00) && (b == 8'h00);

        if (b == 8'hC0 || b == 8'hC1 || b >= 8'hF5)
            saw_illegal = 1'b1;

        // UTF-8 walk: the lead sits four bytes back, its tail is in the window.
        if (n >= 4)
        begin
            if (cont_to_skip != 0)
                cont_to_skip--;
            else if (lookback[0][7:5] == 3'b110)
            begin
                if (is_cont(lookback[1]))
                    saw_multibyte = 1'b1;
                else
                    saw_cont_err = 1'b1;
                cont_to_skip = 2'd1;
            end
            else if (lookback[0][7:4] == 4'b1110)
            begin
                if (is_cont(lookback[1]) && is_cont(lookback[2]))
                    saw_multibyte = 1'b1;
                else
                    saw_cont_err = 1'b1;
                cont_to_skip = 2'd2;
            end
            else if (lookback[0][7:3] == 5'b11110)
            begin
                if (is_cont(lookback[1]) && is_cont(lookback[2]) && is_cont(lookback[3]))
                    saw_multibyte = 1'b1;
                else
                    saw_cont_err = 1'b1;
                cont_to_skip = 2'd3;
            end
        end

        lookback[0] = lookback[1];
        lookback[1] = lookback[2];
        lookback[2] = lookback[3];
        lookback[3] = b;
        if (buf_len != '1)
            buf_len++;

        if (last)
        begin
            // Decision order of the classifier, on the final length.
            if (buf_len < 2)
                verdict = ENC_ANSI;
            else if (zero_words > zero_word_limit)
                verdict = ENC_BINARY;
            else if (head[7:0] == BYTE_FF && head[15:8] == BYTE_FE)
                verdict = ENC_UTF16LE;
            else if (head[7:0] == BYTE_FE && head[15:8] == BYTE_FF)
                verdict = ENC_UTF16BE;
            else if (zero_bytes > ZERO_BYTE_MIN && !buf_len[0])
                verdict = ENC_UTF16LE;
            else if (buf_len < 3)
                verdict = ENC_ANSI;
            else if (head == {UTF8_BOM2, UTF8_BOM1, UTF8_BOM0})
                verdict = ENC_UTF8;
            else if (saw_illegal || saw_cont_err)
                verdict = ENC_ANSI;
            else
                verdict = saw_multibyte ? ENC_UTF8 : ENC_ANSI;
            expected_enc_q.push_back(verdict);
            clear_buffer_stats();
        end
    endtask

    // ------------------------------------------------------------------
    // Byte stream driver
    // ------------------------------------------------------------------

    // One byte transaction. An idle gap lowers valid first; with no gap,
    // valid stays high straight into the next transaction.
    task automatic send_byte(input octet_t b, input logic last);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid     <= 1'b1;
        byte_in.data_byte <= b;
        byte_in.last_byte <= last;
        do @(posedge clk); while (byte_in.ready !== 1'b1);
        absorb_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_pkt();
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
    endtask

    // Stop offering bytes and wait until every predicted result has been
    // taken, then let the pipeline settle.
    task automatic wait_drained();
        byte_in.valid <= 1'b0;
        while (expected_enc_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Limit writes only happen with the block idle.
    task automatic write_zero_word_limit(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        zero_word_limit = value;
    endtask

    // Fill pkt with roughly len bytes of one text kind.
    task automatic build_text(input text_kind_t kind, input int len);
        int     n_cont;
        octet_t lead;
        octet_t ch;
        pkt.delete();
        case (kind)
            TXT_ASCII:
                while (pkt.size() < len)
                    pkt.push_back(octet_t'($urandom_range(8'h20, 8'h7E)));
            TXT_UTF8:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    pkt.push_back(UTF8_BOM0);
                    pkt.push_back(UTF8_BOM1);
                    pkt.push_back(UTF8_BOM2);
                end
                while (pkt.size() < len)
                begin
                    case ($urandom_range(0, 5))
                        3:
                        begin
                            lead   = octet_t'($urandom_range(8'hC2, 8'hDF));
                            n_cont = 1;
                        end
                        4:
                        begin
                            lead   = octet_t'($urandom_range(8'hE0, 8'hEF));
                            n_cont = 2;
                        end
                        5:
                        begin
                            lead   = octet_t'($urandom_range(8'hF0, 8'hF4));
                            n_cont = 3;
                        end
                        default:
                        begin
                            lead   = octet_t'($urandom_range(8'h20, 8'h7E));
                            n_cont = 0;
                        end
                    endcase
                    pkt.push_back(lead);
                    // Now and then a broken tail byte.
                    repeat (n_cont)
                        pkt.push_back(($urandom_range(0, 7) == 0) ? octet_t'($urandom)
                                      : octet_t'($urandom_range(8'h80, 8'hBF)));
                end
            end
            TXT_UTF16LE, TXT_UTF16BE:
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    pkt.push_back(kind == TXT_UTF16LE ? BYTE_FF : BYTE_FE);
                    pkt.push_back(kind == TXT_UTF16LE ? BYTE_FE : BYTE_FF);
                end
                while (pkt.size() < len)
                begin
                    ch = octet_t'($urandom_range(8'h20, 8'h7E));
                    pkt.push_back(kind == TXT_UTF16LE ? ch : 8'h00);
                    pkt.push_back(kind == TXT_UTF16LE ? 8'h00 : ch);
                end
                // Odd length now and then.
                if ($urandom_range(0, 3) == 0 && pkt.size() > 1)
                    void'(pkt.pop_back());
            end
            TXT_NULLS:
                while (pkt.size() < len)
                    pkt.push_back(($urandom_range(0, 3) == 0) ? octet_t'($urandom) : 8'h00);
            default:
                while (pkt.size() < len)
                    pkt.push_back(octet_t'($urandom));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: ready driver, checker, watchdog
    // ------------------------------------------------------------------

    // Per result a random stall, or the long hold-off when one is requested.
    initial
    begin : result_sink
        int stall;
        enc_out.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_len > 0)
            begin
                enc_out.ready <= 1'b0;
                repeat (hold_off_len) @(posedge clk);
                hold_off_len = 0;
            end
            else if (sink_idle_on)
            begin
                stall = $urandom_range(0, 15);
                if (stall > 0)
                begin
                    enc_out.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            enc_out.ready <= 1'b1;
            do @(posedge clk); while (enc_out.valid !== 1'b1);
        end
    end

    // Each result transaction against the oldest prediction.
    always @(posedge clk)
    begin : check_results
        encoding_t want;
        if (rst_n && enc_out.valid === 1'b1 && enc_out.ready === 1'b1)
        begin
            if (expected_enc_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result %0d with no buffer pending", $realtime,
                             enc_out.encoding);
            end
            else
            begin
                want = expected_enc_q.pop_front();
                if (enc_out.encoding !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: encoding mismatch: expected %0d (%s) actual %0d",
                                 $realtime, want, want.name(), enc_out.encoding);
                end
            end
        end
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (byte_in.valid === 1'b1 && byte_in.ready === 1'b1)
                   || (enc_out.valid === 1'b1 && enc_out.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Buffers of one and two bytes: length rules and the UTF-16 marks alone.
    task automatic test_short_buffers();
        pkt = '{8'h00};               send_pkt();
        pkt = '{8'hFF};               send_pkt();
        pkt = '{BYTE_FF, BYTE_FE};    send_pkt();
        pkt = '{BYTE_FE, BYTE_FF};    send_pkt();
        pkt = '{8'h41, 8'h42};        send_pkt();
        pkt = '{8'h00, 8'h00};        send_pkt();
    endtask

    // UTF-8 mark beats illegal bytes; zero words beat the UTF-16 mark.
    task automatic test_byte_order_marks();
        pkt = '{UTF8_BOM0, UTF8_BOM1, UTF8_BOM2};          send_pkt();
        pkt = '{UTF8_BOM0, UTF8_BOM1, UTF8_BOM2, 8'hC0};   send_pkt();
        pkt = '{UTF8_BOM0, UTF8_BOM1, 8'h41};              send_pkt();
        pkt = '{BYTE_FF, BYTE_FE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_pkt();
        pkt = '{BYTE_FF, BYTE_FE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00};
        send_pkt();
    endtask

    // Two, three and four byte sequences, a broken tail, a sticky error,
    // illegal bytes and a lead too close to the end to be walked.
    task automatic test_utf8_walk();
        pkt = '{8'h41, 8'hC3, 8'hA9, 8'h41, 8'h41, 8'h41};          send_pkt();
        pkt = '{8'hC3, 8'h41, 8'h41, 8'h41, 8'h41};                 send_pkt();
        pkt = '{8'hE2, 8'h82, 8'hAC, 8'h41, 8'h41};                 send_pkt();
        pkt = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41};                 send_pkt();
        pkt = '{8'hC3, 8'h41, 8'hE2, 8'h82, 8'hAC, 8'h41, 8'h41};   send_pkt();
        pkt = '{8'h41, 8'h41, 8'hC3};                               send_pkt();
        pkt = '{8'h41, 8'hC0, 8'h41};                               send_pkt();
        pkt = '{8'h41, 8'hF5, 8'h41};                               send_pkt();
        pkt = '{8'h41, 8'hFF, 8'h41, 8'h42};                        send_pkt();
    endtask

    // Zero words right at and just past the default limit, and zero bytes
    // for even and odd lengths.
    task automatic test_null_counts();
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41};                  send_pkt();
        pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h41};    send_pkt();
        pkt = '{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00};    send_pkt();
        pkt = '{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00,
                8'h45, 8'h00};
        send_pkt();
        pkt = '{8'h41, 8'h00, 8'h42, 8'h00, 8'h43, 8'h00, 8'h44, 8'h00,
                8'h45, 8'h00, 8'h46};
        send_pkt();
    endtask

    // Limit of zero, then the top value against a saturated zero-word count.
    task automatic test_limit_extremes();
        write_zero_word_limit(8'd0);
        pkt = '{8'h00, 8'h00, 8'h41};   send_pkt();
        pkt = '{8'h41, 8'h42, 8'h43};   send_pkt();

        // 514 zeros give 256 counted zero words; the count sticks at 255,
        // which never exceeds a limit of 255.
        write_zero_word_limit(8'd255);
        repeat (514) pkt.push_back(8'h00);
        send_pkt();

        write_zero_word_limit(LIMIT_RESET);
    endtask

    // Results held off while bytes keep coming, so the block backs up into
    // its input; then a stream with one full drain in the middle.
    task automatic test_backpressure();
        int i;
        wait_drained();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_off_len = HOLD_OFF_CYCLES;
        for (i = 0; i < 40; i++)
        begin
            build_text(TXT_NOISE, $urandom_range(1, 3));
            send_pkt();
        end
        wait_drained();

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (i = 0; i < 12; i++)
        begin
            build_text(TXT_UTF8, $urandom_range(5, 10));
            send_pkt();
            if (i == 5)
                wait_drained();
        end
        wait_drained();
    endtask

    // Mixed random buffers, mostly short; idling reshuffled in stretches,
    // the limit rewritten now and then.
    task automatic test_random_buffers();
        int         start;
        int         next_cfg;
        int         buffers;
        int         len;
        logic [7:0] limit;
        start    = bytes_sent;
        next_cfg = start + CFG_INTERVAL;
        buffers  = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (buffers % 25 == 0)
            begin
                src_idle_on  = ($urandom_range(0, 2) != 0);
                sink_idle_on = ($urandom_range(0, 2) != 0);
            end
            if (bytes_sent >= next_cfg)
            begin
                case ($urandom_range(0, 4))
                    0: limit = 8'd0;
                    1: limit = 8'd255;
                    2: limit = 8'd254;
                    3: limit = LIMIT_RESET;
                    default: limit = 8'($urandom);
                endcase
                write_zero_word_limit(limit);
                next_cfg += CFG_INTERVAL;
            end
            else if ($urandom_range(0, 19) == 0)
                wait_drained();
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 80)
                                               : $urandom_range(1, 16);
            build_text(text_kind_t'($urandom_range(0, 5)), len);
            send_pkt();
            buffers++;
        end
        wait_drained();
    endtask

    initial
    begin
        cfg_we            <= 1'b0;
        cfg_wdata         <= 8'h00;
        byte_in.valid     <= 1'b0;
        byte_in.data_byte <= 8'h00;
        byte_in.last_byte <= 1'b0;
        src_idle_on       = 1'b1;
        sink_idle_on      = 1'b1;
        hold_off_len      = 0;
        zero_word_limit   = LIMIT_RESET;
        clear_buffer_stats();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_buffers();
        test_byte_order_marks();
        test_utf8_walk();
        test_null_counts();
        test_limit_extremes();
        test_backpressure();
        test_random_buffers();

        wait_drained();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
